>>> rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// An antecedent that forces a consequent at the next clock edge.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// An antecedent that forces a consequent at the same clock edge.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/pfd_pkg.sv
`default_nettype none

package pfd_pkg;

	localparam int DATA_BITS_DEF = 8;
	localparam int LIMIT_W       = 8;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SHORT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG  = 2'd3;

	localparam logic [LIMIT_W-1:0] SHORT_RST = 8'd20;
	localparam logic [LIMIT_W-1:0] ONE_RST   = 8'd40;
	localparam logic [LIMIT_W-1:0] ZERO_RST  = 8'd60;
	localparam logic [LIMIT_W-1:0] LONG_RST  = 8'd80;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SYNC,
		PH_BITS
	} phase_t;

	typedef enum logic [1:0] {
		ST_GOOD   = 2'd0,
		ST_PARITY = 2'd1,
		ST_TIMING = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CL_EARLY,
		CL_ONE,
		CL_ZERO,
		CL_SYNC,
		CL_LATE
	} interval_class_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] short_limit;
		logic [LIMIT_W-1:0] one_limit;
		logic [LIMIT_W-1:0] zero_limit;
		logic [LIMIT_W-1:0] long_limit;
	} limits_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] edge_interval;
		logic               timeout;
	} item_t;

	typedef struct packed {
		interval_class_t cls;
		logic            sync_ok;
	} class_info_t;

	typedef struct packed {
		logic       valid;
		status_t    status;
		logic [7:0] data_byte;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/pfd_classify.sv
`default_nettype none

module pfd_classify (
	input  wire logic [pfd_pkg::LIMIT_W-1:0] edge_interval,
	input  wire pfd_pkg::limits_t           limits,
	output pfd_pkg::class_info_t            info
);

	// The tests run in a fixed order so that unordered limits still give one answer.
	always_comb begin
		info.sync_ok = (edge_interval >= limits.zero_limit) &&
			(edge_interval <= limits.long_limit);
		priority if (edge_interval < limits.short_limit) begin
			info.cls = pfd_pkg::CL_EARLY;
		end else if (edge_interval < limits.one_limit) begin
			info.cls = pfd_pkg::CL_ONE;
		end else if (edge_interval < limits.zero_limit) begin
			info.cls = pfd_pkg::CL_ZERO;
		end else if (edge_interval <= limits.long_limit) begin
			info.cls = pfd_pkg::CL_SYNC;
		end else begin
			info.cls = pfd_pkg::CL_LATE;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/pfd_frame.sv
`default_nettype none

module pfd_frame #(
	parameter int DATA_BITS = pfd_pkg::DATA_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 take,
	input  wire pfd_pkg::item_t       item,
	input  wire pfd_pkg::class_info_t info,
	output pfd_pkg::result_t          res
);

	localparam int BLW = $clog2(DATA_BITS + 2);
	localparam logic [BLW-1:0] BITS_START = BLW'(DATA_BITS + 1);
	localparam logic [BLW-1:0] BITS_LAST  = BLW'(1);

	pfd_pkg::phase_t    phase_q, phase_d;
	logic [BLW-1:0]     bits_left_q, bits_left_d;
	logic [DATA_BITS:0] shift_q, shift_d;
	logic [DATA_BITS:0] shift_in;
	logic [DATA_BITS+7:0] data_ext;
	logic               is_bit;
	logic               last_bit;

	assign is_bit   = (info.cls == pfd_pkg::CL_ONE) || (info.cls == pfd_pkg::CL_ZERO);
	assign last_bit = (bits_left_q == BITS_LAST);
	assign shift_in = {shift_q[DATA_BITS-1:0], info.cls == pfd_pkg::CL_ONE};
	assign data_ext = {8'd0, shift_in[DATA_BITS:1]};

	always_comb begin
		phase_d = phase_q;
		if (take) begin
			if (item.timeout) begin
				phase_d = pfd_pkg::PH_IDLE;
			end else begin
				unique case (phase_q)
					pfd_pkg::PH_IDLE: begin
						phase_d = pfd_pkg::PH_SYNC;
					end
					pfd_pkg::PH_SYNC: begin
						phase_d = info.sync_ok ? pfd_pkg::PH_BITS : pfd_pkg::PH_IDLE;
					end
					pfd_pkg::PH_BITS: begin
						if (info.cls == pfd_pkg::CL_SYNC) begin
							phase_d = pfd_pkg::PH_BITS;
						end else if (is_bit && !last_bit) begin
							phase_d = pfd_pkg::PH_BITS;
						end else begin
							phase_d = pfd_pkg::PH_IDLE;
						end
					end
					default: begin
						phase_d = pfd_pkg::PH_IDLE;
					end
				endcase
			end
		end
	end

	always_comb begin
		bits_left_d   = bits_left_q;
		shift_d       = shift_q;
		res.valid     = 1'b0;
		res.status    = pfd_pkg::ST_GOOD;
		res.data_byte = 8'd0;
		if (take) begin
			if (item.timeout || phase_q == pfd_pkg::PH_IDLE) begin
				bits_left_d = '0;
				shift_d     = '0;
			end else if (phase_q == pfd_pkg::PH_SYNC) begin
				bits_left_d = info.sync_ok ? BITS_START : '0;
				shift_d     = '0;
			end else if (phase_q == pfd_pkg::PH_BITS) begin
				if (info.cls == pfd_pkg::CL_SYNC) begin
					bits_left_d = BITS_START;
					shift_d     = '0;
				end else if (is_bit) begin
					if (last_bit) begin
						// Data and parity together must hold an odd number of ones.
						bits_left_d   = '0;
						shift_d       = '0;
						res.valid     = 1'b1;
						res.status    = (^shift_in) ? pfd_pkg::ST_GOOD : pfd_pkg::ST_PARITY;
						res.data_byte = data_ext[7:0];
					end else begin
						bits_left_d = bits_left_q - BITS_LAST;
						shift_d     = shift_in;
					end
				end else begin
					bits_left_d = '0;
					shift_d     = '0;
					res.valid   = 1'b1;
					res.status  = pfd_pkg::ST_TIMING;
				end
			end else begin
				bits_left_d = '0;
				shift_d     = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= pfd_pkg::PH_IDLE;
			bits_left_q <= '0;
			shift_q     <= '0;
		end else begin
			phase_q     <= phase_d;
			bits_left_q <= bits_left_d;
			shift_q     <= shift_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/pulse_interval_frame_decoder_core.sv
// Pulse-interval frame decoder.
// Input channel (in_valid / in_stall): one request per qualified rising edge,
// carrying the interval since the previous edge, or a timeout marker.
// Output channel (out_valid / out_stall): one request per finished frame,
// carrying the status (good, parity error, timing error) and the data byte.
// Limits are written through cfg_we / cfg_index / cfg_wdata; the user must
// write them only while idle, which the block itself does not enforce. A
// request is classified and folded into the frame state as it leaves the
// input register; a result it completes is presented from the result register.
// Throughput: one request per cycle while no stalled result is pending; the
// limit compares, the shift and the parity reduction all sit between the input
// register and the result register. When the receiver stalls, the pending
// result holds; one more request may enter the input register, after which
// in_stall rises until the result goes. Reset clears the frame state to idle,
// empties both registers and loads the default limits 20, 40, 60 and 80.
`default_nettype none

module pulse_interval_frame_decoder_core #(
	parameter int DATA_BITS = pfd_pkg::DATA_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [pfd_pkg::LIMIT_W-1:0]     edge_interval,
	input  wire logic                            timeout,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [1:0]                           status,
	output logic [7:0]                           data_byte,
	input  wire logic                            cfg_we,
	input  wire logic [pfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pfd_pkg::LIMIT_W-1:0]     cfg_wdata
);

	pfd_pkg::limits_t     limits_q;
	pfd_pkg::item_t       item_s1;
	logic                 valid_s1;
	pfd_pkg::class_info_t info;
	pfd_pkg::result_t     res;
	logic                 valid_s2;
	pfd_pkg::status_t     status_s2;
	logic [7:0]           data_s2;
	logic                 advance;
	logic                 accept;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.short_limit <= pfd_pkg::SHORT_RST;
			limits_q.one_limit   <= pfd_pkg::ONE_RST;
			limits_q.zero_limit  <= pfd_pkg::ZERO_RST;
			limits_q.long_limit  <= pfd_pkg::LONG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfd_pkg::CFG_SHORT: limits_q.short_limit <= cfg_wdata;
				pfd_pkg::CFG_ONE:   limits_q.one_limit   <= cfg_wdata;
				pfd_pkg::CFG_ZERO:  limits_q.zero_limit  <= cfg_wdata;
				pfd_pkg::CFG_LONG:  limits_q.long_limit  <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.edge_interval <= edge_interval;
			item_s1.timeout       <= timeout;
		end
	end

	pfd_classify u_classify (
		.edge_interval (item_s1.edge_interval),
		.limits        (limits_q),
		.info          (info)
	);

	pfd_frame #(
		.DATA_BITS (DATA_BITS)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (valid_s1 && advance),
		.item   (item_s1),
		.info   (info),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res.valid) begin
			status_s2 <= res.status;
			data_s2   <= res.data_byte;
		end
	end

	assign out_valid = valid_s2;
	assign status    = status_s2;
	assign data_byte = data_s2;

endmodule

`default_nettype wire

>>> rtl/core/pfd_checker.sv
`default_nettype none
`include "assert_macros.svh"

module pfd_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          timeout,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [1:0]                    status,
	input wire logic [7:0]                    data_byte
);

	// A stalled result stays presented and unchanged.
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(data_byte))

	// A timing error always reports a zero data byte.
	`ASSERT_SAME(a_timing_zero, out_valid && status == pfd_pkg::ST_TIMING, data_byte == 8'd0)

	// A new result is always caused by a non-timeout request that passed the input register.
	`ASSERT_SAME(a_result_cause, $rose(out_valid), $past(in_valid && !in_stall, 2) && !$past(timeout, 2))

	// The status code for the unused value never shows.
	`ASSERT_ALWAYS(a_status_legal, !out_valid || status != 2'd3)

endmodule

bind pulse_interval_frame_decoder_core pfd_checker u_pfd_checker (.*);

`default_nettype wire
